// ===== hdl/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// ffba_pkg - shared types for the first-fit block allocator
// Request and response beats, result codes and the command and status
// groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package ffba_pkg;

  // Address space of the heap and width of the limit register.
  localparam int ADDR_BITS  = 20;
  localparam int LIMIT_BITS = ADDR_BITS + 1;

  // Limit register value after reset.
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(1048576);

  // Request type codes.
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Response status codes.
  typedef enum logic [2:0] {
    STATUS_OK         = 3'd0,
    STATUS_NULL       = 3'd1,
    STATUS_HEAP_FULL  = 3'd2,
    STATUS_TABLE_FULL = 3'd3,
    STATUS_UNKNOWN    = 3'd4
  } status_t;

  // One request beat.
  typedef struct packed {
    logic                 req_type;
    logic [ADDR_BITS-1:0] req_size;
    logic [ADDR_BITS-1:0] address;
  } req_t;

  // One response beat.
  typedef struct packed {
    status_t              status;
    logic [ADDR_BITS-1:0] payload_address;
    logic [ADDR_BITS-1:0] granted_size;
    logic                 reused;
  } rsp_t;

  // Outcome of one request, chosen by the controller.
  typedef enum logic [2:0] {
    RES_NULL,
    RES_TABLE_FULL,
    RES_HEAP_FULL,
    RES_UNKNOWN,
    RES_ALLOC_HIT,
    RES_FREE_HIT,
    RES_GROW
  } res_kind_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic      load_req;
    logic      scan_start;
    logic      scan_step;
    logic      finish;
    res_kind_t kind;
  } ctrl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic req_is_free;
    logic req_null;
    logic scan_hit;
    logic scan_miss;
    logic table_full;
    logic heap_ok;
  } dp_status_t;

endpackage

// ===== hdl/first_fit_block_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_block_allocator - first-fit heap block allocator
// Top level: joins the request sequencer to the block table datapath.
// ----------------------------------------------------------------------------
// One request is handled at a time. A free of a null address or an allocate
// of zero bytes goes straight from the first rounding state to the response,
// with no table walk. Any other request walks the block table through its
// single registered read port, one entry a cycle; an allocate first passes
// both rounding states, a free only the first. A response waits in an output
// register; the input reopens at the edge that loads it, so the next request
// can be taken in the following cycle, but that request cannot complete until
// the register frees. The heap limit may be written at any idle moment and
// takes effect on the next request.
module first_fit_block_allocator #(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEADER_BYTES = 32,
  parameter int ALIGN_BYTES  = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  ffba_pkg::req_t                  in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output ffba_pkg::rsp_t                  out_data,
  input  logic                            cfg_we,
  input  logic [ffba_pkg::LIMIT_BITS-1:0] cfg_wdata
);

  ffba_pkg::ctrl_cmd_t  cmd;
  ffba_pkg::dp_status_t status;

  // Request sequencer.
  ffba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  // Block table and heap datapath.
  ffba_datapath #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES),
    .ALIGN_BYTES  (ALIGN_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_data  (out_data)
  );

endmodule

// ===== hdl/ffba_datapath.sv =====
// ----------------------------------------------------------------------------
// ffba_datapath - block table, heap state and arithmetic
// Holds the block table memory, the heap top, the block count and the limit
// register. Rounds the request size, walks the table one entry a cycle and
// builds the response beat on command from the controller.
// ----------------------------------------------------------------------------
module ffba_datapath #(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEADER_BYTES = 32,
  parameter int ALIGN_BYTES  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  ffba_pkg::req_t                      in_data,
  input  ffba_pkg::ctrl_cmd_t                 cmd,
  output ffba_pkg::dp_status_t                status,
  input  logic                                cfg_we,
  input  logic [ffba_pkg::LIMIT_BITS-1:0]     cfg_wdata,
  output ffba_pkg::rsp_t                      out_data
);

  localparam int AW      = ffba_pkg::ADDR_BITS;
  localparam int X_W     = AW + 1;
  localparam int IDX_W   = $clog2(MAX_BLOCKS);
  localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
  // Reciprocal of the alignment, exact for every operand below 2^X_W.
  localparam int SHIFT   = X_W + 8;
  localparam int RECIP_W = SHIFT + 1;
  localparam int PROD_W  = X_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) / ALIGN_BYTES) + 1);
  localparam logic [X_W-1:0] ALIGN_M1 = X_W'(ALIGN_BYTES - 1);
  localparam logic [X_W-1:0] ALIGN_K  = X_W'(ALIGN_BYTES);
  localparam logic [X_W-1:0] HEADER_K = X_W'(HEADER_BYTES);
  localparam logic [X_W-1:0] CAP      = X_W'(1) << AW;

  typedef struct packed {
    logic [AW-1:0] start;
    logic [AW-1:0] bytes;
    logic          is_free;
  } entry_t;

  // Request and heap state.
  ffba_pkg::req_t     req;
  logic [X_W-1:0]     heap_limit;
  logic [X_W-1:0]     heap_top;
  logic [CNT_W-1:0]   block_count;

  // Size rounding pipeline.
  logic [X_W-1:0]     round_x;
  logic [PROD_W-1:0]  prod;
  logic [X_W-1:0]     size_r;

  // Block table and scan state.
  entry_t             mem [MAX_BLOCKS];
  entry_t             rd_q;
  logic [CNT_W-1:0]   rd_idx;
  logic               pend;
  logic [IDX_W-1:0]   pend_idx;
  logic               hit;
  logic [IDX_W-1:0]   hit_idx;
  entry_t             hit_entry;

  // Combinational helpers.
  logic [X_W-1:0]     lim;
  logic [X_W:0]       grow_end;
  logic               rd_more;
  logic               alloc_match;
  logic               free_match;
  logic               entry_match;
  logic [X_W-1:0]     pa_hit;
  logic [X_W-1:0]     pa_grow;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  entry_t             mem_wdata;

  // Limit, growth check and match conditions.
  always_comb begin
    round_x     = {1'b0, req.req_size} + ALIGN_M1;
    lim         = (heap_limit > CAP) ? CAP : heap_limit;
    grow_end    = {1'b0, heap_top} + {1'b0, HEADER_K} + {1'b0, size_r};
    rd_more     = rd_idx < block_count;
    alloc_match = rd_q.is_free && ({1'b0, rd_q.bytes} >= size_r);
    free_match  = ({1'b0, rd_q.start} + HEADER_K) == {1'b0, req.address};
    entry_match = (req.req_type == ffba_pkg::REQ_FREE) ? free_match : alloc_match;
    pa_hit      = {1'b0, hit_entry.start} + HEADER_K;
    pa_grow     = heap_top + HEADER_K;
  end

  // Status towards the controller.
  always_comb begin
    status.req_is_free = req.req_type == ffba_pkg::REQ_FREE;
    status.req_null    = (req.req_type == ffba_pkg::REQ_FREE) ?
                         (req.address == '0) : (req.req_size == '0);
    status.scan_hit    = hit;
    status.scan_miss   = !hit && !pend && !rd_more;
    status.table_full  = block_count >= CNT_W'(MAX_BLOCKS);
    status.heap_ok     = grow_end <= {1'b0, lim};
  end

  // Table write on completion: mark a hit entry or append a new block.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = hit_idx;
    mem_wdata = hit_entry;
    case (cmd.kind)
      ffba_pkg::RES_ALLOC_HIT: begin
        mem_we            = cmd.finish;
        mem_wdata.is_free = 1'b0;
      end
      ffba_pkg::RES_FREE_HIT: begin
        mem_we            = cmd.finish;
        mem_wdata.is_free = 1'b1;
      end
      ffba_pkg::RES_GROW: begin
        mem_we            = cmd.finish;
        mem_waddr         = block_count[IDX_W-1:0];
        mem_wdata.start   = heap_top[AW-1:0];
        mem_wdata.bytes   = size_r[AW-1:0];
        mem_wdata.is_free = 1'b0;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Block table memory with a registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[rd_idx[IDX_W-1:0]];
  end

  // Size rounding: multiply by the reciprocal, then back by the alignment.
  always_ff @(posedge clk) begin
    prod   <= PROD_W'(round_x) * PROD_W'(RECIP);
    size_r <= prod[SHIFT +: X_W] * ALIGN_K;
  end

  // Request capture and scan payload.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req <= in_data;
    end
    if (cmd.scan_step) begin
      pend_idx <= rd_idx[IDX_W-1:0];
    end
    if (cmd.scan_step && !hit && pend && entry_match) begin
      hit_idx   <= pend_idx;
      hit_entry <= rd_q;
    end
  end

  // Heap state, limit register and scan control.
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_limit  <= ffba_pkg::LIMIT_RESET;
      heap_top    <= '0;
      block_count <= '0;
      rd_idx      <= '0;
      pend        <= 1'b0;
      hit         <= 1'b0;
    end else begin
      if (cfg_we) begin
        heap_limit <= cfg_wdata;
      end
      if (cmd.finish && cmd.kind == ffba_pkg::RES_GROW) begin
        block_count <= block_count + CNT_W'(1);
        heap_top    <= grow_end[X_W-1:0];
      end
      if (cmd.scan_start) begin
        rd_idx <= '0;
        pend   <= 1'b0;
        hit    <= 1'b0;
      end else if (cmd.scan_step && !hit) begin
        pend <= rd_more;
        if (rd_more) begin
          rd_idx <= rd_idx + CNT_W'(1);
        end
        if (pend && entry_match) begin
          hit <= 1'b1;
        end
      end
    end
  end

  // Response beat register.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data.payload_address <= '0;
      out_data.granted_size    <= '0;
      out_data.reused          <= 1'b0;
      case (cmd.kind)
        ffba_pkg::RES_NULL:       out_data.status <= ffba_pkg::STATUS_NULL;
        ffba_pkg::RES_TABLE_FULL: out_data.status <= ffba_pkg::STATUS_TABLE_FULL;
        ffba_pkg::RES_HEAP_FULL:  out_data.status <= ffba_pkg::STATUS_HEAP_FULL;
        ffba_pkg::RES_UNKNOWN:    out_data.status <= ffba_pkg::STATUS_UNKNOWN;
        ffba_pkg::RES_ALLOC_HIT: begin
          out_data.status          <= ffba_pkg::STATUS_OK;
          out_data.payload_address <= pa_hit[AW-1:0];
          out_data.granted_size    <= hit_entry.bytes;
          out_data.reused          <= 1'b1;
        end
        ffba_pkg::RES_FREE_HIT: begin
          out_data.status       <= ffba_pkg::STATUS_OK;
          out_data.granted_size <= hit_entry.bytes;
        end
        ffba_pkg::RES_GROW: begin
          out_data.status          <= ffba_pkg::STATUS_OK;
          out_data.payload_address <= pa_grow[AW-1:0];
          out_data.granted_size    <= size_r[AW-1:0];
        end
        default: out_data.status <= ffba_pkg::STATUS_NULL;
      endcase
    end
  end

endmodule

// ===== hdl/ffba_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffba_ctrl - request sequencer for the first-fit block allocator
// Accepts one request at a time, steps the datapath through rounding and the
// table walk, picks the outcome and hands the response beat to the output.
// ----------------------------------------------------------------------------
module ffba_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ffba_pkg::ctrl_cmd_t  cmd,
  input  ffba_pkg::dp_status_t status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROUND1,
    S_ROUND2,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t              state;
  ffba_pkg::res_kind_t kind;
  logic                accept;
  logic                out_free;

  // Handshake terms and commands to the datapath.
  always_comb begin
    accept         = in_valid && !in_stall;
    out_free       = !out_valid || !out_stall;
    cmd.load_req   = accept;
    cmd.scan_start = (state == S_ROUND1 && status.req_is_free) || (state == S_ROUND2);
    cmd.scan_step  = state == S_SCAN;
    cmd.finish     = (state == S_FINISH) && out_free;
    cmd.kind       = kind;
  end

  // Sequencer state and registered handshake outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      kind      <= ffba_pkg::RES_NULL;
      in_stall  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            in_stall <= 1'b1;
            state    <= S_ROUND1;
          end
        end
        S_ROUND1: begin
          if (status.req_null) begin
            kind  <= ffba_pkg::RES_NULL;
            state <= S_FINISH;
          end else if (status.req_is_free) begin
            state <= S_SCAN;
          end else begin
            state <= S_ROUND2;
          end
        end
        S_ROUND2: begin
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (status.scan_hit) begin
            kind  <= status.req_is_free ? ffba_pkg::RES_FREE_HIT : ffba_pkg::RES_ALLOC_HIT;
            state <= S_FINISH;
          end else if (status.scan_miss) begin
            if (status.req_is_free) begin
              kind <= ffba_pkg::RES_UNKNOWN;
            end else if (status.table_full) begin
              kind <= ffba_pkg::RES_TABLE_FULL;
            end else if (!status.heap_ok) begin
              kind <= ffba_pkg::RES_HEAP_FULL;
            end else begin
              kind <= ffba_pkg::RES_GROW;
            end
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            in_stall <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // An accepted request closes the input until its response is built.
  a_stall_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("input not stalled after an accepted beat");

  // The input is open only while the sequencer is idle.
  a_open_only_idle: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> state == S_IDLE)
    else $error("input open outside the idle state");

  // A response beat appears only as a request completes.
  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FINISH))
    else $error("response beat without a completed request");

  // A table walk never reports a hit and a miss together.
  a_hit_or_miss: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && status.scan_hit) |-> !status.scan_miss)
    else $error("table walk reports hit and miss at once");
`endif

endmodule

// ===== dv/first_fit_block_allocator_test.sv =====
// ----------------------------------------------------------------------------
// first_fit_block_allocator_test - self-checking bench for the allocator
// Sends allocate and free request beats with random gaps against a receiver
// that stalls at random. A behavioural copy of the block table predicts each
// response beat, and the beats are checked in order across several heap
// limit settings.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_test;

  localparam int ADDR_BITS   = ffba_pkg::ADDR_BITS;
  localparam int LIMIT_BITS  = ffba_pkg::LIMIT_BITS;
  localparam int SLOTS       = 64;
  localparam int HDR         = 32;
  localparam int ALIGN       = 16;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_AT     = 100;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 170;
  localparam logic [ADDR_BITS-1:0]  FIELD_MAX = '1;
  localparam logic [LIMIT_BITS-1:0] LIMIT_MAX = '1;

  // One row of the directed plan: either a limit write or a request beat,
  // the latter optionally with its response written out by hand.
  typedef struct {
    bit                    is_cfg;
    logic [LIMIT_BITS-1:0] limit;
    ffba_pkg::req_t        req;
    bit                    typed;
    ffba_pkg::rsp_t        rsp;
  } plan_row_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  ffba_pkg::req_t        in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  ffba_pkg::rsp_t        out_data;
  logic                  cfg_we    = 1'b0;
  logic [LIMIT_BITS-1:0] cfg_wdata = '0;

  // Predicted allocator state: one entry per heap segment.
  longint seg_base  [SLOTS];
  longint seg_size  [SLOTS];
  bit     seg_avail [SLOTS];
  int     seg_count = 0;
  longint brk       = 0;
  longint limit_now = longint'(ffba_pkg::LIMIT_RESET);

  ffba_pkg::rsp_t pending_rsp [$];
  plan_row_t      dir_plan [$];
  int             mismatch_count = 0;
  int             beats_seen     = 0;
  int             cycle_count    = 0;
  int             stall_left     = 0;
  bit             stalling       = 1'b0;
  bit             hold_done      = 1'b0;

  first_fit_block_allocator #(
    .MAX_BLOCKS   (SLOTS),
    .HEADER_BYTES (HDR),
    .ALIGN_BYTES  (ALIGN)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Works out the response to one request and updates the segment table.
  function automatic ffba_pkg::rsp_t allocator_answer(ffba_pkg::req_t r);
    ffba_pkg::rsp_t a;
    longint         rounded;
    longint         ceiling;
    int             hit;
    int             i;
    a = '0;
    hit = -1;
    if (r.req_type == ffba_pkg::REQ_ALLOC) begin
      if (r.req_size == '0) begin
        a.status = ffba_pkg::STATUS_NULL;
      end else begin
        rounded = ((longint'(r.req_size) + ALIGN - 1) / ALIGN) * ALIGN;
        for (i = 0; i < seg_count; i++) begin
          if (hit < 0 && seg_avail[i] && seg_size[i] >= rounded) hit = i;
        end
        // The limit register is wider than the address space, so saturate it.
        ceiling = (limit_now > (longint'(1) << ADDR_BITS)) ?
                  (longint'(1) << ADDR_BITS) : limit_now;
        if (hit >= 0) begin
          seg_avail[hit]    = 1'b0;
          a.status          = ffba_pkg::STATUS_OK;
          a.payload_address = ADDR_BITS'(seg_base[hit] + HDR);
          a.granted_size    = ADDR_BITS'(seg_size[hit]);
          a.reused          = 1'b1;
        end else if (seg_count >= SLOTS) begin
          a.status = ffba_pkg::STATUS_TABLE_FULL;
        end else if (brk + HDR + rounded > ceiling) begin
          a.status = ffba_pkg::STATUS_HEAP_FULL;
        end else begin
          seg_base[seg_count]  = brk;
          seg_size[seg_count]  = rounded;
          seg_avail[seg_count] = 1'b0;
          seg_count++;
          a.status          = ffba_pkg::STATUS_OK;
          a.payload_address = ADDR_BITS'(brk + HDR);
          a.granted_size    = ADDR_BITS'(rounded);
          brk += HDR + rounded;
        end
      end
    end else if (r.address == '0) begin
      a.status = ffba_pkg::STATUS_NULL;
    end else begin
      for (i = 0; i < seg_count; i++) begin
        if (hit < 0 && seg_base[i] + HDR == longint'(r.address)) hit = i;
      end
      if (hit >= 0) begin
        seg_avail[hit] = 1'b1;
        a.status       = ffba_pkg::STATUS_OK;
        a.granted_size = ADDR_BITS'(seg_size[hit]);
      end else begin
        a.status = ffba_pkg::STATUS_UNKNOWN;
      end
    end
    return a;
  endfunction

  // Plan rows: a request checked against the prediction, one with its
  // response given, and a limit write.
  function automatic plan_row_t ask(logic kind, logic [ADDR_BITS-1:0] size,
                                    logic [ADDR_BITS-1:0] addr);
    plan_row_t row;
    row.is_cfg       = 1'b0;
    row.limit        = '0;
    row.req.req_type = kind;
    row.req.req_size = size;
    row.req.address  = addr;
    row.typed        = 1'b0;
    row.rsp          = '0;
    return row;
  endfunction

  function automatic plan_row_t ask_expect(logic kind, logic [ADDR_BITS-1:0] size,
                                           logic [ADDR_BITS-1:0] addr,
                                           ffba_pkg::status_t st,
                                           logic [ADDR_BITS-1:0] pa,
                                           logic [ADDR_BITS-1:0] gs, logic ru);
    plan_row_t row;
    row                     = ask(kind, size, addr);
    row.typed               = 1'b1;
    row.rsp.status          = st;
    row.rsp.payload_address = pa;
    row.rsp.granted_size    = gs;
    row.rsp.reused          = ru;
    return row;
  endfunction

  function automatic plan_row_t set_limit(logic [LIMIT_BITS-1:0] v);
    plan_row_t row;
    row        = ask(ffba_pkg::REQ_ALLOC, '0, '0);
    row.is_cfg = 1'b1;
    row.limit  = v;
    return row;
  endfunction

  // Mostly well-formed traffic: small allocations and frees of live
  // payload addresses, with some noise and odd sizes mixed in.
  function automatic ffba_pkg::req_t random_request();
    ffba_pkg::req_t r;
    int             roll;
    roll       = $urandom_range(0, 99);
    r.req_type = ffba_pkg::REQ_ALLOC;
    r.req_size = ADDR_BITS'($urandom_range(0, FIELD_MAX));
    r.address  = ADDR_BITS'($urandom_range(0, FIELD_MAX));
    if (roll < 40) begin
      r.req_size = ADDR_BITS'($urandom_range(1, 128));
    end else if (roll < 48) begin
      r.req_size = ADDR_BITS'($urandom_range(1, 2048));
    end else if (roll < 50) begin
      // Full-range size, already drawn above.
    end else if (roll < 85) begin
      r.req_type = ffba_pkg::REQ_FREE;
      if (seg_count > 0)
        r.address = ADDR_BITS'(seg_base[$urandom_range(0, seg_count - 1)] + HDR);
    end else if (roll < 92) begin
      r.req_type = ffba_pkg::REQ_FREE;
    end else if (roll < 96) begin
      r.req_type = ffba_pkg::REQ_FREE;
      r.address  = '0;
    end else begin
      r.req_size = '0;
    end
    return r;
  endfunction

  function automatic int sender_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Presents one request beat, holds it until accepted, then records the
  // response that it should produce.
  task automatic offer(ffba_pkg::req_t r, bit typed, ffba_pkg::rsp_t typed_rsp);
    ffba_pkg::rsp_t predicted;
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = allocator_answer(r);
    pending_rsp.push_back(typed ? typed_rsp : predicted);
  endtask

  task automatic pause(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  // The limit is only written once the block has answered everything.
  task automatic write_limit(logic [LIMIT_BITS-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    limit_now = longint'(v);
  endtask

  // Stimulus: directed plan, then four random phases at different limits.
  initial begin : stimulus
    int p;
    int k;
    dir_plan.push_back(ask_expect(ffba_pkg::REQ_FREE, FIELD_MAX, '0,
                                  ffba_pkg::STATUS_NULL, '0, '0, 1'b0));
    dir_plan.push_back(ask_expect(ffba_pkg::REQ_ALLOC, '0, FIELD_MAX,
                                  ffba_pkg::STATUS_NULL, '0, '0, 1'b0));
    dir_plan.push_back(ask_expect(ffba_pkg::REQ_FREE, 20'hA5A5A, 20'd32,
                                  ffba_pkg::STATUS_UNKNOWN, '0, '0, 1'b0));
    dir_plan.push_back(ask_expect(ffba_pkg::REQ_ALLOC, 20'd1, '0,
                                  ffba_pkg::STATUS_OK, 20'd32, 20'd16, 1'b0));
    dir_plan.push_back(ask_expect(ffba_pkg::REQ_ALLOC, 20'd16, FIELD_MAX,
                                  ffba_pkg::STATUS_OK, 20'd80, 20'd16, 1'b0));
    dir_plan.push_back(ask_expect(ffba_pkg::REQ_ALLOC, 20'd17, '0,
                                  ffba_pkg::STATUS_OK, 20'd128, 20'd32, 1'b0));
    dir_plan.push_back(ask_expect(ffba_pkg::REQ_FREE, '0, 20'd32,
                                  ffba_pkg::STATUS_OK, '0, 20'd16, 1'b0));
    // Freeing the same block twice leaves it free and still answers ok.
    dir_plan.push_back(ask_expect(ffba_pkg::REQ_FREE, FIELD_MAX, 20'd32,
                                  ffba_pkg::STATUS_OK, '0, 20'd16, 1'b0));
    // The free block is too small, so the heap grows instead.
    dir_plan.push_back(ask_expect(ffba_pkg::REQ_ALLOC, 20'd20, '0,
                                  ffba_pkg::STATUS_OK, 20'd192, 20'd32, 1'b0));
    dir_plan.push_back(ask_expect(ffba_pkg::REQ_ALLOC, 20'd5, '0,
                                  ffba_pkg::STATUS_OK, 20'd32, 20'd16, 1'b1));
    dir_plan.push_back(ask_expect(ffba_pkg::REQ_FREE, '0, 20'd33,
                                  ffba_pkg::STATUS_UNKNOWN, '0, '0, 1'b0));
    // A size that rounds past the field width can never be met.
    dir_plan.push_back(ask_expect(ffba_pkg::REQ_ALLOC, FIELD_MAX, '0,
                                  ffba_pkg::STATUS_HEAP_FULL, '0, '0, 1'b0));
    dir_plan.push_back(ask_expect(ffba_pkg::REQ_ALLOC, 20'hFFFF0, '0,
                                  ffba_pkg::STATUS_HEAP_FULL, '0, '0, 1'b0));
    dir_plan.push_back(ask_expect(ffba_pkg::REQ_ALLOC, 20'h80000, 20'hA5A5A,
                                  ffba_pkg::STATUS_OK, 20'd256, 20'h80000, 1'b0));
    dir_plan.push_back(ask_expect(ffba_pkg::REQ_FREE, '0, FIELD_MAX,
                                  ffba_pkg::STATUS_UNKNOWN, '0, '0, 1'b0));
    // With the limit below the heap top growth fails, yet old blocks serve.
    dir_plan.push_back(set_limit('0));
    dir_plan.push_back(ask_expect(ffba_pkg::REQ_ALLOC, 20'd16, '0,
                                  ffba_pkg::STATUS_HEAP_FULL, '0, '0, 1'b0));
    dir_plan.push_back(ask_expect(ffba_pkg::REQ_FREE, '0, 20'd80,
                                  ffba_pkg::STATUS_OK, '0, 20'd16, 1'b0));
    dir_plan.push_back(ask_expect(ffba_pkg::REQ_ALLOC, 20'd16, '0,
                                  ffba_pkg::STATUS_OK, 20'd80, 20'd16, 1'b1));
    dir_plan.push_back(ask_expect(ffba_pkg::REQ_FREE, '0, 20'd256,
                                  ffba_pkg::STATUS_OK, '0, 20'h80000, 1'b0));
    dir_plan.push_back(ask(ffba_pkg::REQ_ALLOC, 20'd300000, '0));
    dir_plan.push_back(set_limit(LIMIT_MAX));
    dir_plan.push_back(ask(ffba_pkg::REQ_ALLOC, 20'd1, FIELD_MAX));
    dir_plan.push_back(ask(ffba_pkg::REQ_FREE, 20'h5A5A5, 20'd128));
    dir_plan.push_back(set_limit(ffba_pkg::LIMIT_RESET));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_plan[n]) begin
      if (dir_plan[n].is_cfg) begin
        write_limit(dir_plan[n].limit);
      end else begin
        offer(dir_plan[n].req, dir_plan[n].typed, dir_plan[n].rsp);
        pause(sender_gap());
      end
    end

    for (p = 0; p < 4; p++) begin
      case (p)
        0: write_limit(LIMIT_BITS'(brk + $urandom_range(1024, 8192)));
        1: write_limit(LIMIT_MAX);
        2: write_limit('0);
        default: write_limit(LIMIT_BITS'($urandom_range(0, LIMIT_MAX)));
      endcase
      for (k = 0; k < PHASE_ITEMS; k++) begin
        offer(random_request(), 1'b0, '0);
        // The first fifth of every hundred beats goes back to back.
        if (k % 100 >= 20) pause(sender_gap());
      end
    end

    drain();
    repeat (SLOTS + 8) @(posedge clk);
    if (mismatch_count == 0 && pending_rsp.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Response side: checks each accepted beat against the oldest prediction,
  // then picks the stall for the next cycle.
  always @(posedge clk) begin : collect
    ffba_pkg::rsp_t want;
    int             roll;
    if (!rst && out_valid && !out_stall) begin
      beats_seen++;
      if (pending_rsp.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("response beat %0d with nothing pending: status %0d address %h size %h",
                   beats_seen, out_data.status, out_data.payload_address,
                   out_data.granted_size);
      end else begin
        want = pending_rsp.pop_front();
        if (out_data.status !== want.status ||
            out_data.payload_address !== want.payload_address ||
            out_data.granted_size !== want.granted_size ||
            out_data.reused !== want.reused) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("response beat %0d (expected/actual): status %0d/%0d address %h/%h %s",
                     beats_seen, want.status, out_data.status, want.payload_address,
                     out_data.payload_address,
                     $sformatf("size %h/%h reused %0b/%0b", want.granted_size,
                               out_data.granted_size, want.reused, out_data.reused));
        end
      end
    end

    // One long hold so that the block fills up and stalls its input.
    if (!hold_done && beats_seen >= HOLD_AT) begin
      hold_done  = 1'b1;
      stalling   = 1'b1;
      stall_left = HOLD_CYCLES;
    end else if (stall_left == 0) begin
      stalling = !stalling;
      roll     = $urandom_range(0, 99);
      if (stalling) begin
        stall_left = (roll < 85) ? $urandom_range(1, 3) :
                     (roll < 97) ? $urandom_range(4, 10) : $urandom_range(20, 60);
      end else begin
        stall_left = (roll < 10) ? $urandom_range(50, 150) : $urandom_range(1, 30);
      end
    end
    stall_left--;
    out_stall <= stalling;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule
